FILE: rtl/core/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and codes for the padded record segmenter: operation codes,
// register indexes, the per-item plan and the status groups.
// ----------------------------------------------------------------------------
package prs_pkg;

   // operation codes carried on the request tuser
   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // configuration register indexes
   localparam int  CSR_ADDR_W         = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECORD_KIND    = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MESSAGE_LENGTH = 1'b1;
   localparam int  CSR_DATA_W         = 16;

   // work planned for one accepted item
   typedef struct packed {
      logic       hdr;        // record header goes out first
      logic [7:0] index;      // record index for the header
      logic [7:0] body_val;   // data byte or pad value
      logic [7:0] body_cnt;   // number of body bytes (1..PAYLOAD_BYTES)
      logic       end_flag;   // last body byte closes the record
   } plan_type;

   // planner state summary
   typedef struct packed {
      logic pos_zero;
      logic rec_zero;
   } track_type;

   // emitter handshake summary
   typedef struct packed {
      logic busy;
      logic emit;
      logic emit_last;
   } emit_status_type;

endpackage

FILE: rtl/core/prs_planner.sv
// ----------------------------------------------------------------------------
// prs_planner
// Tracks payload position and record number, and turns each accepted item
// into a plan: header or not, body value, body byte count and record end.
// ----------------------------------------------------------------------------
module prs_planner #(
   parameter int PAYLOAD_BYTES = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               operation,
   input  logic [7:0]         data_byte,
   output prs_pkg::plan_type  plan,
   output prs_pkg::track_type track
);
   import prs_pkg::*;

   localparam int POS_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       rec_ff, rec_in;
   logic [15:0]      pos_inc;
   logic [15:0]      pad_wide;
   logic             data_end;

   // decode the item against the current position
   always_comb begin
      pos_inc  = 16'(pos_ff) + 16'd1;
      pad_wide = 16'(PAYLOAD_BYTES) - 16'(pos_ff);
      data_end = (pos_inc >= 16'(PAYLOAD_BYTES));

      plan.hdr   = (pos_ff == '0);
      plan.index = rec_ff;
      if (operation == OP_DATA) begin
         plan.body_val = data_byte;
         plan.body_cnt = 8'd1;
         plan.end_flag = data_end;
      end else begin
         plan.body_val = pad_wide[7:0];
         plan.body_cnt = pad_wide[7:0];
         plan.end_flag = 1'b1;
      end
   end

   // advance position and record number on data, clear both on finish
   always_comb begin
      pos_in = pos_ff;
      rec_in = rec_ff;
      if (req_fire) begin
         if (operation == OP_DATA) begin
            if (data_end) begin
               pos_in = '0;
               rec_in = rec_ff + 8'd1;
            end else begin
               pos_in = pos_inc[POS_W-1:0];
            end
         end else begin
            pos_in = '0;
            rec_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rec_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         rec_ff <= rec_in;
      end
   end

   assign track.pos_zero = (pos_ff == '0);
   assign track.rec_zero = (rec_ff == '0);

endmodule

FILE: rtl/core/prs_emitter.sv
// ----------------------------------------------------------------------------
// prs_emitter
// Holds one planned item, sending header and body bytes one per cycle unless
// stalled, into the result register; takes next plan as the last byte leaves.
// ----------------------------------------------------------------------------
module prs_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  prs_pkg::plan_type        plan,
   input  logic [7:0]               record_kind,
   input  logic [7:0]               count_byte,
   output logic                     take,
   output prs_pkg::emit_status_type status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);
   import prs_pkg::*;

   // header byte selectors, counted down
   localparam logic [1:0] HDR_KIND  = 2'd3;
   localparam logic [1:0] HDR_COUNT = 2'd2;
   localparam logic [1:0] HDR_INDEX = 2'd1;
   localparam logic [1:0] HDR_DONE  = 2'd0;

   logic       busy_ff, busy_in;
   logic [1:0] hdr_left_ff, hdr_left_in;
   logic [7:0] body_left_ff, body_left_in;
   logic [7:0] body_val_ff, body_val_in;
   logic [7:0] index_ff, index_in;
   logic       end_ff, end_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       out_last_ff, out_last_in;

   logic       emit;
   logic       at_last;
   logic [7:0] cur_byte;

   // send when holding an item and the result register is free
   assign emit    = busy_ff && (!out_valid_ff || rsp_tready);
   assign at_last = (hdr_left_ff == HDR_DONE) && (body_left_ff == 8'd1);
   assign take    = !busy_ff || (emit && at_last);

   // pick the byte to send
   always_comb begin
      case (hdr_left_ff)
         HDR_KIND:  cur_byte = record_kind;
         HDR_COUNT: cur_byte = count_byte;
         HDR_INDEX: cur_byte = index_ff;
         default:   cur_byte = body_val_ff;
      endcase
   end

   // load a plan or count down the held one
   always_comb begin
      busy_in      = busy_ff;
      hdr_left_in  = hdr_left_ff;
      body_left_in = body_left_ff;
      body_val_in  = body_val_ff;
      index_in     = index_ff;
      end_in       = end_ff;
      if (load) begin
         busy_in      = 1'b1;
         hdr_left_in  = plan.hdr ? HDR_KIND : HDR_DONE;
         body_left_in = plan.body_cnt;
         body_val_in  = plan.body_val;
         index_in     = plan.index;
         end_in       = plan.end_flag;
      end else if (emit) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else if (hdr_left_ff != HDR_DONE) begin
            hdr_left_in = hdr_left_ff - 2'd1;
         end else begin
            body_left_in = body_left_ff - 8'd1;
         end
      end
   end

   // fill or drain the result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_end_in   = at_last && end_ff;
         out_last_in  = at_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_left_ff  <= hdr_left_in;
      body_left_ff <= body_left_in;
      body_val_ff  <= body_val_in;
      index_ff     <= index_in;
      end_ff       <= end_in;
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
   end

   assign status.busy      = busy_ff;
   assign status.emit      = emit;
   assign status.emit_last = emit && at_last;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_end_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: rtl/core/padded_record_segmenter.sv
// Path: a request transfer loads the item into the emitter registers, and the
// emitter then sends its first byte into the result register behind rsp_tdata.
// Throughput: one result byte per cycle from the result register while
// rsp_tready allows; an item holds the emitter until its result bytes (1 or 4
// for data, up to PAYLOAD_BYTES + 3 for finish) are sent; the next item is
// taken in the cycle its predecessor's last byte enters the result register.
// Reset: synchronous; resets position, record number, config, busy and valids.
// ----------------------------------------------------------------------------
// padded_record_segmenter
// Cuts a byte message into records of a three-byte header and PAYLOAD_BYTES
// payload bytes, closing each message with PKCS#7-style padding.
// ----------------------------------------------------------------------------
module padded_record_segmenter #(
   parameter int PAYLOAD_BYTES = 17
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write port
   input  logic                                 csr_we,
   input  logic [prs_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [prs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] data_byte
   input  logic                                 req_tuser,  // [0] operation
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [7:0] out_byte
   output logic                                 rsp_tlast,  // run_last
   output logic                                 rsp_tuser   // [0] record_end
);
   import prs_pkg::*;

   // count = length / PAYLOAD_BYTES + 1 via reciprocal multiply, 16-bit exact
   localparam int       SHIFT = 16 + $clog2(PAYLOAD_BYTES);
   localparam longint   RECIP = ((64'd1 << SHIFT) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
   localparam int       PROD_W = 41;

   logic [7:0]        kind_ff, kind_in;
   logic [7:0]        count_ff, count_in;
   logic [PROD_W-1:0] len_prod;
   logic [PROD_W-1:0] len_quot;

   logic              req_fire;
   plan_type          plan;
   track_type         track;
   emit_status_type   emit_st;

   // decode configuration writes; the count byte is formed at write time
   always_comb begin
      len_prod = PROD_W'(csr_wdata) * PROD_W'(RECIP);
      len_quot = len_prod >> SHIFT;
      kind_in  = kind_ff;
      count_in = count_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RECORD_KIND:    kind_in  = csr_wdata[7:0];
            CSR_MESSAGE_LENGTH: count_in = len_quot[7:0] + 8'd1;
            default:            kind_in  = kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= 8'd0;
         count_ff <= 8'd1;
      end else begin
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

   assign req_fire = req_tvalid && req_tready;

   prs_planner #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_planner (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .operation (req_tuser),
      .data_byte (req_tdata),
      .plan      (plan),
      .track     (track)
   );

   prs_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .load         (req_fire),
      .plan         (plan),
      .record_kind  (kind_ff),
      .count_byte   (count_ff),
      .take         (req_tready),
      .status       (emit_st),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

`ifndef SYNTHESIS
   // a busy emitter only takes a new item as its last byte leaves
   a_take_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit_st.busy) |-> emit_st.emit_last)
      else $error("item taken while emitter still has bytes");

   // finish returns the message state to its start
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_FINISH) |=> (track.pos_zero && track.rec_zero))
      else $error("state not cleared after finish");

   // a record end is always the last byte of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("record end before last byte of item");

   // every byte the emitter sends fills the result register
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit_st.emit |=> rsp_tvalid)
      else $error("byte sent but result register empty");
`endif

endmodule
